[hw/rtl/pau_pkg.sv]
// Shared types, constants and the dominance test for the Pareto archive update block.
package pau_pkg;

  localparam int TAG_BITS     = 32;
  localparam int OBJ_BITS     = 16;
  localparam int NUM_OBJ      = 4;
  localparam int OBJ_VEC_W    = NUM_OBJ * OBJ_BITS;
  localparam int CAPACITY_DEF = 32;
  localparam int OUT_CNT_W    = 6;
  localparam int STATUS_W     = 3;

  typedef logic [OBJ_VEC_W-1:0] obj_vec_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED  = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_DOMINATED = 3'd2,
    ST_FULL      = 3'd3,
    ST_CLEARED   = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_COPY,
    S_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic scan_start;
    logic copy_start;
    logic commit;
  } pau_cmd_t;

  typedef struct packed {
    logic pass_busy;
    logic insert_ok;
    logic out_free;
  } pau_sts_t;

  function automatic logic dominates(obj_vec_t a, obj_vec_t b);
    logic le;
    logic lt;
    le = 1'b1;
    lt = 1'b0;
    for (int k = 0; k < NUM_OBJ; k++) begin
      if (a[k*OBJ_BITS +: OBJ_BITS] > b[k*OBJ_BITS +: OBJ_BITS]) le = 1'b0;
      if (a[k*OBJ_BITS +: OBJ_BITS] < b[k*OBJ_BITS +: OBJ_BITS]) lt = 1'b1;
    end
    return le && lt;
  endfunction

endpackage

[hw/rtl/pareto_archive_update.sv]
// Top level of the Pareto archive update block: controller, datapath and checks.
//
//  channel | signals                                         | direction
//  --------+-------------------------------------------------+----------
//  in      | in_valid/in_ready, mode, solution_tag, obj_0..3 | sink
//  out     | out_valid/out_ready, accepted, status,          | source
//          | entry_count, removed_count                      |
//
// Clear item: capture then commit.
// Offer with n > 0 stored entries: a scan pass over the single memory read port and a
// decide step, then on insertion a copy pass into the other bank and a finish step,
// plus capture and commit. A rejected offer skips the copy pass.
// Reset empties the table at once; no memory sweep is needed.
// A finished result waits in the output register; the next item is taken
// meanwhile and stalls only at its own commit until that register frees.
module pareto_archive_update #(
  parameter int CAPACITY = pau_pkg::CAPACITY_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            mode,
  input  logic [pau_pkg::TAG_BITS-1:0]    solution_tag,
  input  logic [pau_pkg::OBJ_BITS-1:0]    obj_0,
  input  logic [pau_pkg::OBJ_BITS-1:0]    obj_1,
  input  logic [pau_pkg::OBJ_BITS-1:0]    obj_2,
  input  logic [pau_pkg::OBJ_BITS-1:0]    obj_3,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            accepted,
  output logic [pau_pkg::STATUS_W-1:0]    status,
  output logic [pau_pkg::OUT_CNT_W-1:0]   entry_count,
  output logic [pau_pkg::OUT_CNT_W-1:0]   removed_count
);
  import pau_pkg::*;

  pau_cmd_t cmd;
  pau_sts_t sts;

  pau_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .mode     (mode),
    .sts      (sts),
    .cmd      (cmd)
  );

  pau_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .mode          (mode),
    .solution_tag  (solution_tag),
    .obj_0         (obj_0),
    .obj_1         (obj_1),
    .obj_2         (obj_2),
    .obj_3         (obj_3),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .accepted      (accepted),
    .status        (status),
    .entry_count   (entry_count),
    .removed_count (removed_count)
  );

`ifndef NO_ASSERTIONS
  a_accept_status: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (accepted == (status == ST_INSERTED)))
    else $error("accepted flag disagrees with status");

  a_removed_only_insert: assert property (@(posedge clk) disable iff (rst)
    (out_valid && removed_count != '0) |-> (status == ST_INSERTED))
    else $error("removed count on a rejected or clear item");

  a_clear_empty: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ST_CLEARED) |-> (entry_count == '0 && removed_count == '0))
    else $error("clear result reports entries");

  a_idle_no_pass: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !sts.pass_busy)
    else $error("input ready while a pass is running");
`endif

endmodule

[hw/rtl/pau_ctrl.sv]
// Controller state machine: sequences capture, scan pass, copy pass and result commit.
module pau_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              mode,
  input  pau_pkg::pau_sts_t sts,
  output pau_pkg::pau_cmd_t cmd
);
  import pau_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (mode) begin
            state_next = S_DONE;
          end else begin
            cmd.scan_start = 1'b1;
            state_next     = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (!sts.pass_busy) begin
          if (sts.insert_ok) begin
            cmd.copy_start = 1'b1;
            state_next     = S_COPY;
          end else begin
            state_next = S_DONE;
          end
        end
      end
      S_COPY: begin
        if (!sts.pass_busy) state_next = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

[hw/rtl/pau_datapath.sv]
// Datapath: double-banked archive memory, scan and copy engine, flags and result register.
module pau_datapath #(
  parameter int CAPACITY = pau_pkg::CAPACITY_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  pau_pkg::pau_cmd_t               cmd,
  output pau_pkg::pau_sts_t               sts,
  input  logic                            mode,
  input  logic [pau_pkg::TAG_BITS-1:0]    solution_tag,
  input  logic [pau_pkg::OBJ_BITS-1:0]    obj_0,
  input  logic [pau_pkg::OBJ_BITS-1:0]    obj_1,
  input  logic [pau_pkg::OBJ_BITS-1:0]    obj_2,
  input  logic [pau_pkg::OBJ_BITS-1:0]    obj_3,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            accepted,
  output logic [pau_pkg::STATUS_W-1:0]    status,
  output logic [pau_pkg::OUT_CNT_W-1:0]   entry_count,
  output logic [pau_pkg::OUT_CNT_W-1:0]   removed_count
);
  import pau_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int ENT_W = TAG_BITS + OBJ_VEC_W;

  logic [ENT_W-1:0]    mem [2][CAPACITY];
  logic [ENT_W-1:0]    rd_data;
  logic [TAG_BITS-1:0] cand_tag;
  obj_vec_t            cand_obj;
  logic                clear_q;
  logic [CNT_W-1:0]    n;
  logic                bank;
  logic [CNT_W-1:0]    rd_idx;
  logic                rd_vld;
  logic                pass_on;
  logic                copy_pass;
  logic                dup_f;
  logic                dom_f;
  logic [CNT_W-1:0]    surv;
  logic [CNT_W-1:0]    wr_idx;

  logic                rd_en;
  logic                e_dup;
  logic                e_dom_c;
  logic                c_dom_e;
  logic                we;
  logic [IDX_W-1:0]    waddr;
  logic [ENT_W-1:0]    wdata;
  logic                room;
  status_t             res_status;
  logic [CNT_W-1:0]    res_count;
  logic [CNT_W-1:0]    res_removed;

  assign rd_en   = pass_on && (rd_idx < n);
  assign e_dup   = (rd_data[ENT_W-1 -: TAG_BITS] == cand_tag);
  assign e_dom_c = dominates(rd_data[OBJ_VEC_W-1:0], cand_obj);
  assign c_dom_e = dominates(cand_obj, rd_data[OBJ_VEC_W-1:0]);
  assign room    = (surv < CNT_W'(CAPACITY));

  assign we    = cmd.copy_start || (rd_vld && copy_pass && !c_dom_e);
  assign waddr = cmd.copy_start ? '0 : wr_idx[IDX_W-1:0];
  assign wdata = cmd.copy_start ? {cand_tag, cand_obj} : rd_data;

  assign sts.pass_busy = pass_on;
  assign sts.insert_ok = !clear_q && !dup_f && !dom_f && room;
  assign sts.out_free  = !out_valid || out_ready;

  always_comb begin
    res_removed = '0;
    res_count   = n;
    if (clear_q) begin
      res_status = ST_CLEARED;
      res_count  = '0;
    end else if (dup_f) begin
      res_status = ST_DUPLICATE;
    end else if (dom_f) begin
      res_status = ST_DOMINATED;
    end else if (!room) begin
      res_status = ST_FULL;
    end else begin
      res_status  = ST_INSERTED;
      res_count   = wr_idx;
      res_removed = n - surv;
    end
  end

  // archive memory: read the live bank, write the other one
  always_ff @(posedge clk) begin
    if (rd_en) rd_data <= mem[bank][rd_idx[IDX_W-1:0]];
    if (we) mem[~bank][waddr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cand_tag <= solution_tag;
      cand_obj <= {obj_3, obj_2, obj_1, obj_0};
      clear_q  <= mode;
    end
    if (cmd.scan_start || cmd.copy_start) begin
      rd_idx    <= '0;
      copy_pass <= cmd.copy_start;
    end else if (rd_en) begin
      rd_idx <= rd_idx + 1'b1;
    end
    if (cmd.scan_start) begin
      dup_f <= 1'b0;
      dom_f <= 1'b0;
      surv  <= '0;
    end else if (rd_vld && !copy_pass) begin
      dup_f <= dup_f | e_dup;
      dom_f <= dom_f | e_dom_c;
      if (!c_dom_e) surv <= surv + 1'b1;
    end
    if (cmd.copy_start) begin
      wr_idx <= CNT_W'(1);
    end else if (rd_vld && copy_pass && !c_dom_e) begin
      wr_idx <= wr_idx + 1'b1;
    end
    if (cmd.commit) begin
      accepted      <= (res_status == ST_INSERTED);
      status        <= res_status;
      entry_count   <= OUT_CNT_W'(res_count);
      removed_count <= OUT_CNT_W'(res_removed);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      n         <= '0;
      bank      <= 1'b0;
      pass_on   <= 1'b0;
      rd_vld    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.scan_start || cmd.copy_start) begin
        pass_on <= 1'b1;
        rd_vld  <= 1'b0;
      end else if (pass_on) begin
        rd_vld <= rd_en;
        if (!rd_en && !rd_vld) pass_on <= 1'b0;
      end
      if (cmd.commit) begin
        out_valid <= 1'b1;
        if (clear_q) begin
          n <= '0;
        end else if (res_status == ST_INSERTED) begin
          n    <= wr_idx;
          bank <= ~bank;
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

[sim/testbench.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the Pareto archive update block, predicted in SystemVerilog.
module testbench;
  import pau_pkg::*;

  localparam int CAP           = CAPACITY_DEF;
  localparam int HOLD_CYCLES   = 400;
  localparam int SETTLE_CYCLES = 80;
  localparam int FRONT_SPAN    = 2000;
  localparam logic MODE_OFFER  = 1'b0;
  localparam logic MODE_CLEAR  = 1'b1;

  typedef struct {
    logic                 acc;
    status_t              st;
    logic [OUT_CNT_W-1:0] cnt;
    logic [OUT_CNT_W-1:0] rem;
  } verdict_t;

  logic                 clk;
  logic                 rst;
  logic                 in_valid;
  logic                 in_ready;
  logic                 mode;
  logic [TAG_BITS-1:0]  solution_tag;
  logic [OBJ_BITS-1:0]  obj_0;
  logic [OBJ_BITS-1:0]  obj_1;
  logic [OBJ_BITS-1:0]  obj_2;
  logic [OBJ_BITS-1:0]  obj_3;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic                 accepted;
  logic [STATUS_W-1:0]  status;
  logic [OUT_CNT_W-1:0] entry_count;
  logic [OUT_CNT_W-1:0] removed_count;

  logic [TAG_BITS-1:0] arc_tag [CAP];
  obj_vec_t            arc_obj [CAP];
  int                  arc_count = 0;

  verdict_t pending_verdicts [$];
  int       idle_pct    = 0;
  int       stall_pct   = 0;
  int       hold_reqs   = 0;
  int       hold_seen   = 0;
  int       hold_left   = 0;
  int       mismatches  = 0;
  int       items_sent  = 0;
  int       results_got = 0;
  int       peak_size   = 0;
  int       outcome_hits [5] = '{0, 0, 0, 0, 0};

  pareto_archive_update u_dut (.*);

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  initial begin
    #(5_000_000);
    $display("status: fail");
    $finish;
  end

  function automatic obj_vec_t pack4(input int a, input int b, input int c, input int d);
    return {OBJ_BITS'(d), OBJ_BITS'(c), OBJ_BITS'(b), OBJ_BITS'(a)};
  endfunction

  function automatic logic beats(input obj_vec_t a, input obj_vec_t b);
    logic                no_worse;
    logic                better;
    logic [OBJ_BITS-1:0] x;
    logic [OBJ_BITS-1:0] y;
    no_worse = 1'b1;
    better   = 1'b0;
    for (int k = 0; k < NUM_OBJ; k++) begin
      x = a[k*OBJ_BITS +: OBJ_BITS];
      y = b[k*OBJ_BITS +: OBJ_BITS];
      if (x > y) no_worse = 1'b0;
      if (x < y) better = 1'b1;
    end
    return no_worse && better;
  endfunction

  function automatic verdict_t archive_predict(input logic m, input logic [TAG_BITS-1:0] tag,
                                               input obj_vec_t cand);
    verdict_t            v;
    int                  keep;
    logic [TAG_BITS-1:0] nt [CAP];
    obj_vec_t            nv [CAP];
    v.acc = 1'b0;
    v.rem = '0;
    v.cnt = OUT_CNT_W'(arc_count);
    if (m == MODE_CLEAR) begin
      arc_count = 0;
      v.st  = ST_CLEARED;
      v.cnt = '0;
      return v;
    end
    for (int i = 0; i < arc_count; i++) begin
      if (arc_tag[i] == tag) begin
        v.st = ST_DUPLICATE;
        return v;
      end
    end
    for (int i = 0; i < arc_count; i++) begin
      if (beats(arc_obj[i], cand)) begin
        v.st = ST_DOMINATED;
        return v;
      end
    end
    keep = 0;
    for (int i = 0; i < arc_count; i++) begin
      if (!beats(cand, arc_obj[i])) keep++;
    end
    if (keep >= CAP) begin
      v.st = ST_FULL;
      return v;
    end
    nt[0] = tag;
    nv[0] = cand;
    keep  = 1;
    for (int i = 0; i < arc_count; i++) begin
      if (!beats(cand, arc_obj[i])) begin
        nt[keep] = arc_tag[i];
        nv[keep] = arc_obj[i];
        keep++;
      end
    end
    v.rem = OUT_CNT_W'(arc_count + 1 - keep);
    for (int i = 0; i < keep; i++) begin
      arc_tag[i] = nt[i];
      arc_obj[i] = nv[i];
    end
    arc_count = keep;
    v.acc = 1'b1;
    v.st  = ST_INSERTED;
    v.cnt = OUT_CNT_W'(keep);
    return v;
  endfunction

  task automatic send_item(input logic m, input logic [TAG_BITS-1:0] tag, input obj_vec_t v);
    verdict_t want;
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    mode         <= m;
    solution_tag <= tag;
    obj_0        <= v[0*OBJ_BITS +: OBJ_BITS];
    obj_1        <= v[1*OBJ_BITS +: OBJ_BITS];
    obj_2        <= v[2*OBJ_BITS +: OBJ_BITS];
    obj_3        <= v[3*OBJ_BITS +: OBJ_BITS];
    do @(posedge clk); while (in_ready !== 1'b1);
    want = archive_predict(m, tag, v);
    pending_verdicts.insert(pending_verdicts.size(), want);
    outcome_hits[want.st]++;
    items_sent++;
    if (arc_count > peak_size) peak_size = arc_count;
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_phase(input int src_idle, input int snk_stall);
    idle_pct  = src_idle;
    stall_pct = snk_stall;
  endtask

  // hold out_ready low on request, otherwise stall at random
  always @(posedge clk) begin
    if (hold_reqs != hold_seen) begin
      hold_seen <= hold_reqs;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    verdict_t want;
    if (!rst && out_valid === 1'b1 && out_ready === 1'b1) begin
      results_got++;
      if (pending_verdicts.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected transfer: accepted %0d status %0d count %0d removed %0d",
                   accepted, status, entry_count, removed_count);
      end else begin
        want = pending_verdicts.pop_front();
        if (accepted !== want.acc || status !== want.st ||
            entry_count !== want.cnt || removed_count !== want.rem) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch at %0t: expected acc %0d st %0d cnt %0d rem %0d, got %0d %0d %0d %0d",
                     $realtime, want.acc, want.st, want.cnt, want.rem,
                     accepted, status, entry_count, removed_count);
        end
      end
    end
  end

  task automatic test_directed;
    send_item(MODE_CLEAR, 32'h0, pack4(0, 0, 0, 0));
    send_item(MODE_OFFER, 32'hFFFF_FFFF, pack4('hFFFF, 'hFFFF, 'hFFFF, 'hFFFF));
    send_item(MODE_OFFER, 32'hFFFF_FFFF, pack4(0, 0, 0, 0));
    send_item(MODE_OFFER, 32'h0000_0001, pack4('hFFFF, 'hFFFF, 'hFFFF, 'hFFFF));
    send_item(MODE_OFFER, 32'h0000_0000, pack4(0, 0, 0, 0));
    send_item(MODE_OFFER, 32'h0000_0002, pack4(1, 0, 0, 0));
    send_item(MODE_OFFER, 32'h0000_0003, pack4(0, 0, 0, 0));
    send_item(MODE_OFFER, 32'h0000_0004, pack4('hFFFF, 0, 0, 0));
    send_item(MODE_CLEAR, 32'hA5A5_5A5A, pack4('hFFFF, 'hFFFF, 'hFFFF, 'hFFFF));
    send_item(MODE_OFFER, 32'h0000_0005, pack4(0, 'hFFFF, 0, 'hFFFF));
    send_item(MODE_OFFER, 32'h0000_0006, pack4('hFFFF, 0, 'hFFFF, 0));
    send_item(MODE_OFFER, 32'h0000_0007, pack4(0, 'hFFFF, 0, 'hFFFE));
    send_item(MODE_OFFER, 32'h8000_0000, pack4('h8000, 'h8000, 'h8000, 'h8000));
    send_item(MODE_OFFER, 32'h8000_0001, pack4('h7FFF, 'h7FFF, 'h7FFF, 'h7FFF));
    drain();
  endtask

  // fill with a front of mutually non-dominating offers until the table is full
  task automatic test_fill_to_capacity;
    int s;
    send_item(MODE_CLEAR, $urandom, pack4(0, 0, 0, 0));
    for (int i = 0; i < CAP + 4; i++) begin
      s = i * 50 + $urandom_range(0, 49);
      send_item(MODE_OFFER, $urandom, pack4(s, FRONT_SPAN - s, $urandom, $urandom));
    end
    drain();
  endtask

  task automatic test_random_mix(input int n_items);
    logic [TAG_BITS-1:0] tag;
    logic [OBJ_BITS-1:0] f;
    obj_vec_t            v;
    int                  kind;
    int                  k;
    int                  s;
    for (int i = 0; i < n_items; i++) begin
      kind = $urandom_range(0, 99);
      tag  = $urandom;
      s    = $urandom_range(0, FRONT_SPAN);
      v    = pack4(s, FRONT_SPAN - s, $urandom_range(0, 3), $urandom_range(0, 3));
      if (kind < 2) begin
        send_item(MODE_CLEAR, tag, v);
        continue;
      end
      if (kind < 18) begin
        v = pack4($urandom_range(0, 15), $urandom_range(0, 15),
                  $urandom_range(0, 15), $urandom_range(0, 15));
      end else if (kind < 28) begin
        v = pack4($urandom, $urandom, $urandom, $urandom);
      end else if (kind < 40 && arc_count > 0) begin
        tag = arc_tag[$urandom_range(0, arc_count - 1)];
      end else if (kind < 52 && arc_count > 0) begin
        v = arc_obj[$urandom_range(0, arc_count - 1)];
        k = $urandom_range(0, NUM_OBJ - 1);
        f = v[k*OBJ_BITS +: OBJ_BITS];
        if (f != 0) v[k*OBJ_BITS +: OBJ_BITS] = f - OBJ_BITS'($urandom_range(1, f));
      end
      send_item(MODE_OFFER, tag, v);
    end
    drain();
  endtask

  // stall the output for a long stretch while offers keep coming
  task automatic test_output_backpressure;
    hold_reqs <= hold_reqs + 1;
    test_random_mix(24);
  endtask

  initial begin
    rst          <= 1'b1;
    in_valid     <= 1'b0;
    mode         <= MODE_OFFER;
    solution_tag <= '0;
    obj_0        <= '0;
    obj_1        <= '0;
    obj_2        <= '0;
    obj_3        <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    set_phase(0, 0);
    test_directed();
    test_fill_to_capacity();
    test_output_backpressure();
    test_random_mix(145);
    set_phase(74, 0);
    test_random_mix(145);
    set_phase(0, 74);
    test_random_mix(145);
    set_phase(29, 29);
    test_random_mix(145);

    $display("archive run: %0d offers and clears sent, %0d results checked, %0d mismatches",
             items_sent, results_got, mismatches);
    $display("outcomes: %0d inserted, %0d duplicate, %0d dominated, %0d full, %0d cleared, peak %0d",
             outcome_hits[ST_INSERTED], outcome_hits[ST_DUPLICATE], outcome_hits[ST_DOMINATED],
             outcome_hits[ST_FULL], outcome_hits[ST_CLEARED], peak_size);
    if (mismatches == 0 && pending_verdicts.size() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/pau_pkg.sv
hw/rtl/pau_ctrl.sv
hw/rtl/pau_datapath.sv
hw/rtl/pareto_archive_update.sv
sim/testbench.sv
